>>> hdl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue_core
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 16;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PRIO_W-1:0] prio_type;
   typedef logic [CNT_W-1:0]         count_type;

   // operation codes of the kind field
   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // operation broadcast to every cell of the chain
   typedef struct packed {
      logic     insert_en;
      logic     remove_en;
      data_type data;
      prio_type prio;
   } cmd_type;

endpackage

>>> hdl/spq_cell.sv
// one slot of the sorted chain: holds a data and priority pair
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
   input  logic     clock,
   input  cmd_type  cmd,
   input  logic     occupied,
   input  logic     left_cond,
   input  data_type left_data,
   input  prio_type left_prio,
   input  data_type right_data,
   input  prio_type right_prio,
   output logic     cond,
   output data_type slot_data,
   output prio_type slot_prio,
   output data_type next_data,
   output prio_type next_prio
);

   data_type data_ff, data_in;
   prio_type prio_ff, prio_in;

   // new item goes ahead of this slot (free slot or strictly lower priority)
   assign cond = !occupied || (cmd.prio > prio_ff);

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (cmd.insert_en) begin
         if (left_cond) begin
            data_in = left_data;
            prio_in = left_prio;
         end else if (cond) begin
            data_in = cmd.data;
            prio_in = cmd.prio;
         end
      end else if (cmd.remove_en) begin
         data_in = right_data;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign slot_data = data_ff;
   assign slot_prio = prio_ff;
   assign next_data = data_in;
   assign next_prio = prio_in;

endmodule

>>> hdl/sorted_priority_queue_core.sv
// top level of the sorted priority queue: a chain of spq_cell slots
// depends on spq_pkg and spq_cell
//
//   channel   ports                                  handshake
//   -------   -------------------------------------  --------------------------
//   request   req_kind, req_item_data,               taken when start && !busy
//             req_item_priority
//   response  rsp_status, rsp_head_data,             one cycle, marked rsp_valid
//             rsp_head_priority, rsp_fill_count,
//             rsp_is_full_flag, rsp_is_empty_flag
//
// all slots update in parallel at the accept edge, and the response
// shows up in the following cycle
// busy is always low, so a new item may be started in every cycle
// synchronous reset empties the queue (count to zero); slot contents are
// not cleared, slots at or above the count never reach a response
// the receiver cannot stall, responses are never held back
module sorted_priority_queue_core import spq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_kind,
   input  logic signed [DATA_W-1:0] req_item_data,
   input  logic signed [PRIO_W-1:0] req_item_priority,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_head_data,
   output logic signed [PRIO_W-1:0] rsp_head_priority,
   output logic [CNT_W-1:0]         rsp_fill_count,
   output logic                     rsp_is_full_flag,
   output logic                     rsp_is_empty_flag
);

   // control state
   count_type  count_ff, count_in;
   logic       valid_ff, valid_in;
   // response payload
   status_type status_ff, status_in;
   data_type   head_data_ff, head_data_in;
   prio_type   head_prio_ff, head_prio_in;

   logic       accept;
   logic       queue_full;
   logic       queue_empty;
   cmd_type    cmd;

   // chain wiring, one entry per slot
   logic       occ       [CAPACITY];
   logic       cond      [CAPACITY];
   logic       left_cond [CAPACITY];
   data_type   slot_data [CAPACITY];
   prio_type   slot_prio [CAPACITY];
   data_type   next_data [CAPACITY];
   prio_type   next_prio [CAPACITY];
   data_type   left_data [CAPACITY];
   prio_type   left_prio [CAPACITY];
   data_type   right_data[CAPACITY];
   prio_type   right_prio[CAPACITY];

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign queue_full  = (count_ff == count_type'(CAPACITY));
   assign queue_empty = (count_ff == '0);

   // broadcast the operation; rejected operations leave every slot alone
   always_comb begin
      cmd.insert_en = accept && (req_kind == KIND_INSERT) && !queue_full;
      cmd.remove_en = accept && (req_kind == KIND_REMOVE) && !queue_empty;
      cmd.data      = req_item_data;
      cmd.prio      = req_item_priority;
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
         // slots below the count hold entries, sorted highest first
         assign occ[i] = (count_ff > count_type'(i));

         // insert shifts toward the tail, remove shifts toward the head
         if (i == 0) begin : g_head
            assign left_cond[i] = 1'b0;
            assign left_data[i] = req_item_data;
            assign left_prio[i] = req_item_priority;
         end else begin : g_body
            assign left_cond[i] = cond[i-1];
            assign left_data[i] = slot_data[i-1];
            assign left_prio[i] = slot_prio[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            // tail slot empties on remove, its contents no longer matter
            assign right_data[i] = slot_data[i];
            assign right_prio[i] = slot_prio[i];
         end else begin : g_inner
            assign right_data[i] = slot_data[i+1];
            assign right_prio[i] = slot_prio[i+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (occ[i]),
            .left_cond  (left_cond[i]),
            .left_data  (left_data[i]),
            .left_prio  (left_prio[i]),
            .right_data (right_data[i]),
            .right_prio (right_prio[i]),
            .cond       (cond[i]),
            .slot_data  (slot_data[i]),
            .slot_prio  (slot_prio[i]),
            .next_data  (next_data[i]),
            .next_prio  (next_prio[i])
         );
      end
   endgenerate

   // count and response for the accepted item
   always_comb begin
      count_in     = count_ff;
      valid_in     = accept;
      status_in    = status_ff;
      head_data_in = head_data_ff;
      head_prio_in = head_prio_ff;

      if (cmd.insert_en) begin
         count_in = count_ff + count_type'(1);
      end else if (cmd.remove_en) begin
         count_in = count_ff - count_type'(1);
      end

      if (accept) begin
         if (req_kind == KIND_INSERT) begin
            status_in = queue_full ? STATUS_FULL : STATUS_DONE;
         end else begin
            status_in = queue_empty ? STATUS_EMPTY : STATUS_DONE;
         end

         if (cmd.remove_en) begin
            // report the entry that leaves
            head_data_in = slot_data[0];
            head_prio_in = slot_prio[0];
         end else if (count_in == '0) begin
            head_data_in = '0;
            head_prio_in = '0;
         end else begin
            // head as it stands after this step
            head_data_in = next_data[0];
            head_prio_in = next_prio[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // fill state travels with the response, taken from the new count
   logic resp_full_ff, resp_empty_ff;
   count_type resp_count_ff;

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      head_data_ff  <= head_data_in;
      head_prio_ff  <= head_prio_in;
      resp_count_ff <= count_in;
      resp_full_ff  <= (count_in == count_type'(CAPACITY));
      resp_empty_ff <= (count_in == '0);
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_data     = head_data_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_fill_count    = resp_count_ff;
   assign rsp_is_full_flag  = resp_full_ff;
   assign rsp_is_empty_flag = resp_empty_ff;

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for sorted_priority_queue_core: directed and random
// insert/remove items checked against a sorted-list predictor, depends on spq_pkg
module tb import spq_pkg::*; ();

   // one pending operation for the driver, with the sender idle rate of its phase
   typedef struct {
      kind_type kind;
      data_type data;
      prio_type prio;
      int       idle_pct;
   } queue_op_type;

   // one expected response
   typedef struct {
      status_type status;
      data_type   head_data;
      prio_type   head_prio;
      count_type  fill;
      logic       full;
      logic       empty;
   } head_report_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_kind = KIND_INSERT;
   logic signed [DATA_W-1:0] req_item_data = '0;
   logic signed [PRIO_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_head_data;
   logic signed [PRIO_W-1:0] rsp_head_priority;
   logic [CNT_W-1:0]         rsp_fill_count;
   logic                     rsp_is_full_flag;
   logic                     rsp_is_empty_flag;

   queue_op_type    pending_ops[$];
   head_report_type expected_heads[$];
   int              error_count = 0;

   // predictor state: sorted slots, index 0 holds the highest priority
   data_type slot_data[CAPACITY];
   prio_type slot_prio[CAPACITY];
   int       stored = 0;

   // driver scratch
   logic            holding;
   head_report_type got_head;

   sorted_priority_queue_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_is_full_flag  (rsp_is_full_flag),
      .rsp_is_empty_flag (rsp_is_empty_flag)
   );

   // 12 unit clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // reset held from time zero, released once and never raised again
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // apply one operation to the sorted list and report the resulting head
   function automatic head_report_type apply_queue_op(kind_type kind, data_type d,
                                                      prio_type p);
      head_report_type r;
      int              idx;
      logic            took;
      r.status    = STATUS_DONE;
      r.head_data = '0;
      r.head_prio = '0;
      took        = 1'b0;
      if (kind == KIND_INSERT) begin
         if (stored >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            // walk up past every strictly lower priority, ties keep arrival order
            idx = stored;
            while (idx > 0 && p > slot_prio[idx-1]) begin
               slot_data[idx] = slot_data[idx-1];
               slot_prio[idx] = slot_prio[idx-1];
               idx--;
            end
            slot_data[idx] = d;
            slot_prio[idx] = p;
            stored++;
         end
      end else begin
         if (stored == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            // the removed entry is what gets reported
            r.head_data = slot_data[0];
            r.head_prio = slot_prio[0];
            took = 1'b1;
            for (idx = 1; idx < stored; idx++) begin
               slot_data[idx-1] = slot_data[idx];
               slot_prio[idx-1] = slot_prio[idx];
            end
            stored--;
         end
      end
      // otherwise the head after the step, zero when nothing is left
      if (!took && r.status != STATUS_EMPTY && stored > 0) begin
         r.head_data = slot_data[0];
         r.head_prio = slot_prio[0];
      end
      r.fill  = count_type'(stored);
      r.full  = (stored == CAPACITY);
      r.empty = (stored == 0);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_op(kind_type kind, data_type d, prio_type p, int idle_pct);
      queue_op_type op;
      op.kind     = kind;
      op.data     = d;
      op.prio     = p;
      op.idle_pct = idle_pct;
      pending_ops.push_back(op);
   endtask

   // priority mix: a narrow band for lots of ties, the extremes, and the full range
   function automatic prio_type pick_priority();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) begin
         return prio_type'(int'($urandom_range(3)) - 2);
      end else if (sel == 4) begin
         return $urandom_range(1) ? prio_type'(16'h7fff) : prio_type'(16'h8000);
      end
      return prio_type'($urandom);
   endfunction

   function automatic data_type pick_data();
      int sel;
      sel = $urandom_range(15);
      if (sel == 0) begin
         return data_type'(32'h7fff_ffff);
      end else if (sel == 1) begin
         return data_type'(32'h8000_0000);
      end
      return data_type'($urandom);
   endfunction

   // stimulus: directed opening, then random phases with different sender idle rates
   initial begin
      int phase_idle[4];
      int phase;
      int n;
      int burst_left;
      int insert_pct;
      phase_idle[0] = 0;
      phase_idle[1] = 70;
      phase_idle[2] = 0;
      phase_idle[3] = 6;

      // remove from an empty queue
      add_op(KIND_REMOVE, data_type'(32'h1234_5678), prio_type'(16'h7fff), 0);
      // extremes of data and priority, equal levels to check arrival order
      add_op(KIND_INSERT, data_type'(32'h7fff_ffff), prio_type'(16'h7fff), 0);
      add_op(KIND_INSERT, data_type'(32'h8000_0000), prio_type'(16'h8000), 0);
      add_op(KIND_INSERT, data_type'(0),             prio_type'(0),        0);
      add_op(KIND_INSERT, data_type'(32'hffff_ffff), prio_type'(-1),       0);
      add_op(KIND_INSERT, data_type'(1),             prio_type'(1),        0);
      add_op(KIND_INSERT, data_type'(2),             prio_type'(1),        0);
      add_op(KIND_INSERT, data_type'(3),             prio_type'(1),        0);
      add_op(KIND_INSERT, data_type'(10),            prio_type'(16'h7fff), 0);
      add_op(KIND_INSERT, data_type'(11),            prio_type'(16'h8000), 0);
      add_op(KIND_INSERT, data_type'(12),            prio_type'(0),        0);
      add_op(KIND_INSERT, data_type'(13),            prio_type'(-1),       0);
      add_op(KIND_INSERT, data_type'(14),            prio_type'(1),        0);
      add_op(KIND_INSERT, data_type'(15),            prio_type'(16'h7ffe), 0);
      add_op(KIND_INSERT, data_type'(16),            prio_type'(16'h8001), 0);
      add_op(KIND_INSERT, data_type'(17),            prio_type'(1),        0);
      add_op(KIND_INSERT, data_type'(18),            prio_type'(0),        0);
      // queue is full now, this one bounces
      add_op(KIND_INSERT, data_type'(32'h5555_aaaa), prio_type'(16'h7fff), 0);
      repeat (7) add_op(KIND_REMOVE, data_type'($urandom), prio_type'($urandom), 0);

      // random part: bursts that lean toward filling or draining so the queue
      // keeps running into both full and empty
      burst_left = 0;
      insert_pct = 50;
      for (phase = 0; phase < 4; phase++) begin
         for (n = 0; n < 440; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(40, 8);
               case ($urandom_range(2))
                  0: insert_pct = 85;
                  1: insert_pct = 15;
                  default: insert_pct = 50;
               endcase
            end
            burst_left--;
            if ($urandom_range(99) < insert_pct) begin
               add_op(KIND_INSERT, pick_data(), pick_priority(), phase_idle[phase]);
            end else begin
               // payload of a remove is ignored, keep it random anyway
               add_op(KIND_REMOVE, data_type'($urandom), prio_type'($urandom),
                      phase_idle[phase]);
            end
         end
      end
   end

   // driver: take note of the accepted item, then present the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_heads.push_back(apply_queue_op(kind_type'(req_kind), req_item_data,
                                                    req_item_priority));
         end
         // an item that was not taken stays on the ports unchanged
         holding = start && busy;
         if (!holding) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= pending_ops[0].idle_pct) begin
               start             <= 1'b1;
               req_kind          <= pending_ops[0].kind;
               req_item_data     <= pending_ops[0].data;
               req_item_priority <= pending_ops[0].prio;
               void'(pending_ops.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed response is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_heads.size() == 0) begin
            report_mismatch("response with no item outstanding");
         end else begin
            got_head = expected_heads.pop_front();
            if (rsp_status !== got_head.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, got_head.status));
            if (rsp_head_data !== got_head.head_data)
               report_mismatch($sformatf("head data %h, expected %h",
                                         rsp_head_data, got_head.head_data));
            if (rsp_head_priority !== got_head.head_prio)
               report_mismatch($sformatf("head priority %0d, expected %0d",
                                         rsp_head_priority, got_head.head_prio));
            if (rsp_fill_count !== got_head.fill)
               report_mismatch($sformatf("fill count %0d, expected %0d",
                                         rsp_fill_count, got_head.fill));
            if (rsp_is_full_flag !== got_head.full)
               report_mismatch($sformatf("full flag %b, expected %b",
                                         rsp_is_full_flag, got_head.full));
            if (rsp_is_empty_flag !== got_head.empty)
               report_mismatch($sformatf("empty flag %b, expected %b",
                                         rsp_is_empty_flag, got_head.empty));
         end
      end
   end

   // end of run: all items sent and answered, then a short drain for strays
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      do @(negedge clock);
      while (pending_ops.size() != 0 || start || expected_heads.size() != 0);
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(12 * 200000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
tb/sv/tb.sv
